// ----- hdl/sapp_pkg.sv -----
// Shared widths, codes and types for the session send admission policer.
// No dependencies; every module of the block imports this package.
`default_nettype none
package sapp_pkg;

  localparam int TIME_W   = 48;
  localparam int QDEPTH   = 64;
  localparam int FRAC_W   = 20;
  localparam int CAP_W    = 24;
  localparam int TOK_W    = CAP_W + FRAC_W;
  localparam int RATE_W   = 32;
  localparam int LEN_W    = 16;
  localparam int TOT_W    = 25;
  localparam int MUL_W    = 24;
  localparam int NCH      = (TIME_W + MUL_W - 1) / MUL_W;
  localparam int PAD_W    = NCH * MUL_W;
  localparam int PROD_W   = MUL_W + RATE_W;
  localparam int ACC_W    = PAD_W + RATE_W;
  localparam int IDX_W    = $clog2(NCH);
  localparam int HEAD_W   = $clog2(QDEPTH);
  localparam int CNT_W    = $clog2(QDEPTH + 1);
  localparam int ADDR_W   = 5;

  typedef enum logic [2:0] {
    CMD_ENQ      = 3'd0,
    CMD_DEQ      = 3'd1,
    CMD_RECV     = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_HB_QUERY = 3'd4,
    CMD_HB_SENT  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_CONN  = 3'd1,
    ST_RATE_LIM  = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_OVF_DISC  = 3'd4,
    ST_TIMEOUT   = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OVF_DISCONNECT = 2'd0,
    OVF_DROP_OLD   = 2'd1,
    OVF_REJECT     = 2'd2
  } ovf_t;

  typedef enum logic [2:0] {
    REG_CAPACITY  = 3'd0,
    REG_REFILL    = 3'd1,
    REG_QLIMIT    = 3'd2,
    REG_OVF_MODE  = 3'd3,
    REG_RX_TMO    = 3'd4,
    REG_HB_PERIOD = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_ACC,
    S_REFILL,
    S_CHARGE,
    S_DROP,
    S_DROP_WAIT,
    S_PUSH,
    S_DEQ_WAIT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/session_send_admission_policer.sv -----
// Top level of the session send admission policer: sequencer, state, config.
// Depends on sapp_pkg, sapp_mul and sapp_lenq.
//
// One command is taken when start is high and busy is low; busy stays high
// until its single result word has been shown with done for one cycle. The
// receiver cannot stall: each result word is valid only in its done cycle.
// Receive, tick, heartbeat, unused codes, an empty dequeue and an enqueue
// while disconnected go from the execute state straight to done; a dequeue
// that returns a length adds a wait for the queue read. An enqueue with a
// full bucket goes to the charge step, plus a push when the length is queued.
// A refill runs the elapsed time through one 24x32 multiplier one chunk at a
// time, a multiply and an accumulate step per chunk, then a refill step.
// Drop-oldest adds a drop step plus a wait and a drop per popped length.
`default_nettype none
module session_send_admission_policer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  cmd,
  input  wire logic [sapp_pkg::TIME_W-1:0] now,
  input  wire logic [sapp_pkg::LEN_W-1:0]  msg_length,
  output logic                             done,
  output logic                             ok,
  output logic [2:0]                       status,
  output logic [sapp_pkg::LEN_W-1:0]       out_length,
  output logic [sapp_pkg::TOT_W-1:0]       queued_total,
  output logic                             is_connected,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sapp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sapp_pkg::*;

  // configuration registers
  logic [CAP_W-1:0]  bucket_capacity;
  logic [RATE_W-1:0] refill_per_unit;
  logic [CAP_W-1:0]  queue_limit_bytes;
  logic [1:0]        overflow_mode;
  logic [31:0]       receive_timeout;
  logic [31:0]       heartbeat_period;

  // session state
  state_t             state, state_next;
  logic [TOK_W-1:0]   token_level;
  logic [TIME_W-1:0]  last_refill_time;
  logic [TIME_W-1:0]  last_receive_time;
  logic [TIME_W-1:0]  last_heartbeat_time;
  logic               session_up;
  logic [HEAD_W-1:0]  fifo_head;
  logic [CNT_W-1:0]   fifo_count;
  logic [TOT_W-1:0]   byte_total;

  // latched command and working registers
  logic [2:0]         cmd_q;
  logic [TIME_W-1:0]  now_q;
  logic [LEN_W-1:0]   len_q;
  logic [PAD_W-1:0]   dt_pad;
  logic [ACC_W-1:0]   acc;
  logic [IDX_W-1:0]   idx;
  logic               res_ok;
  logic [2:0]         res_status;
  logic [LEN_W-1:0]   res_len;

  logic [PROD_W-1:0]  prod;
  logic [LEN_W-1:0]   head_len;
  logic [MUL_W-1:0]   mul_a;

  logic [TOK_W-1:0]   cap;
  logic [TOK_W-1:0]   room;
  logic [TOK_W-1:0]   need;
  logic [TIME_W-1:0]  dt_refill;
  logic [TIME_W-1:0]  dt_recv;
  logic [TIME_W-1:0]  dt_hb;
  logic               over_limit;
  logic               acc_over;
  logic [CNT_W:0]     tail_sum;
  logic [HEAD_W-1:0]  tail;
  logic [HEAD_W-1:0]  head_inc;
  logic               cfg_we;
  logic [2:0]         cfg_idx;

  assign cap       = {bucket_capacity, FRAC_W'(0)};
  assign room      = cap - token_level;
  assign need      = {(TOK_W - FRAC_W - LEN_W)'(0), len_q, FRAC_W'(0)};
  assign dt_refill = (now_q >= last_refill_time) ? now_q - last_refill_time : '0;
  assign dt_recv   = (now_q >= last_receive_time) ? now_q - last_receive_time : '0;
  assign dt_hb     = (now_q >= last_heartbeat_time) ? now_q - last_heartbeat_time : '0;
  assign over_limit = ((TOT_W + 1)'(byte_total) + (TOT_W + 1)'(len_q)
                        > (TOT_W + 1)'(queue_limit_bytes))
                      || (fifo_count >= CNT_W'(QDEPTH));
  assign acc_over  = (|acc[ACC_W-1:TOK_W]) || (acc[TOK_W-1:0] > room);
  assign tail_sum  = (CNT_W + 1)'(fifo_head) + (CNT_W + 1)'(fifo_count);
  assign tail      = (tail_sum >= (CNT_W + 1)'(QDEPTH))
                     ? HEAD_W'(tail_sum - (CNT_W + 1)'(QDEPTH)) : HEAD_W'(tail_sum);
  assign head_inc  = ((CNT_W)'(fifo_head) + CNT_W'(1) >= CNT_W'(QDEPTH))
                     ? '0 : fifo_head + HEAD_W'(1);
  assign mul_a     = dt_pad[idx*MUL_W +: MUL_W];

  sapp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (refill_per_unit),
    .p   (prod)
  );

  sapp_lenq u_lenq (
    .clk   (clk),
    .we    (state == S_PUSH),
    .waddr (tail),
    .wdata (len_q),
    .raddr (fifo_head),
    .rdata (head_len)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_CAPACITY:  prdata = 32'(bucket_capacity);
      REG_REFILL:    prdata = refill_per_unit;
      REG_QLIMIT:    prdata = 32'(queue_limit_bytes);
      REG_OVF_MODE:  prdata = 32'(overflow_mode);
      REG_RX_TMO:    prdata = receive_timeout;
      REG_HB_PERIOD: prdata = heartbeat_period;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity   <= CAP_W'(65536);
      refill_per_unit   <= RATE_W'(1048576);
      queue_limit_bytes <= CAP_W'(262144);
      overflow_mode     <= OVF_REJECT;
      receive_timeout   <= 32'd30000000;
      heartbeat_period  <= 32'd5000000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CAPACITY:  bucket_capacity   <= pwdata[CAP_W-1:0];
        REG_REFILL:    refill_per_unit   <= pwdata;
        REG_QLIMIT:    queue_limit_bytes <= pwdata[CAP_W-1:0];
        REG_OVF_MODE:  overflow_mode     <= pwdata[1:0];
        REG_RX_TMO:    receive_timeout   <= pwdata;
        REG_HB_PERIOD: heartbeat_period  <= pwdata;
        default: ;
      endcase
    end
  end

  // result word
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign ok           = res_ok;
  assign status       = res_status;
  assign out_length   = res_len;
  assign queued_total = byte_total;
  assign is_connected = session_up;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (cmd_q == CMD_ENQ && session_up) begin
          state_next = (token_level >= cap) ? S_CHARGE : S_MUL;
        end else if (cmd_q == CMD_DEQ && fifo_count != '0) begin
          state_next = S_DEQ_WAIT;
        end
      end
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = (idx == '0) ? S_REFILL : S_MUL;
      S_REFILL: state_next = S_CHARGE;
      S_CHARGE: begin
        state_next = S_DONE;
        if (token_level >= need) begin
          if (!over_limit) begin
            state_next = S_PUSH;
          end else if (overflow_mode == OVF_DROP_OLD) begin
            state_next = S_DROP;
          end
        end
      end
      S_DROP:      state_next = (fifo_count != '0 && over_limit) ? S_DROP_WAIT : S_PUSH;
      S_DROP_WAIT: state_next = S_DROP;
      S_PUSH:      state_next = S_DONE;
      S_DEQ_WAIT:  state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // session control state
  always_ff @(posedge clk) begin
    if (rst) begin
      token_level         <= {CAP_W'(65536), FRAC_W'(0)};
      last_refill_time    <= '0;
      last_receive_time   <= '0;
      last_heartbeat_time <= '0;
      session_up          <= 1'b1;
      fifo_head           <= '0;
      fifo_count          <= '0;
      byte_total          <= '0;
    end else begin
      unique case (state)
        S_EXEC: begin
          unique case (cmd_q)
            CMD_ENQ: begin
              if (session_up) begin
                last_refill_time <= now_q;
                if (token_level >= cap) begin
                  token_level <= cap;
                end
              end
            end
            CMD_RECV:    last_receive_time <= now_q;
            CMD_HB_SENT: last_heartbeat_time <= now_q;
            CMD_TICK: begin
              if (session_up && dt_recv >= TIME_W'(receive_timeout)) begin
                session_up <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_REFILL: begin
          token_level <= acc_over ? cap : token_level + acc[TOK_W-1:0];
        end
        S_CHARGE: begin
          if (token_level >= need) begin
            token_level <= token_level - need;
            if (over_limit && overflow_mode == OVF_DISCONNECT) begin
              session_up <= 1'b0;
            end
          end
        end
        S_DROP_WAIT, S_DEQ_WAIT: begin
          // pop the head length
          fifo_head  <= head_inc;
          fifo_count <= fifo_count - CNT_W'(1);
          byte_total <= (byte_total >= TOT_W'(head_len)) ? byte_total - TOT_W'(head_len) : '0;
        end
        S_PUSH: begin
          fifo_count <= fifo_count + CNT_W'(1);
          byte_total <= byte_total + TOT_W'(len_q);
        end
        default: ;
      endcase
    end
  end

  // command latch, refill product and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd_q <= cmd;
        now_q <= now;
        len_q <= msg_length;
      end
      S_EXEC: begin
        dt_pad     <= PAD_W'(dt_refill);
        acc        <= '0;
        idx        <= IDX_W'(NCH - 1);
        res_ok     <= 1'b0;
        res_status <= ST_OK;
        res_len    <= '0;
        unique case (cmd_q)
          CMD_ENQ: begin
            if (!session_up) res_status <= ST_NOT_CONN;
          end
          CMD_DEQ: begin
            if (fifo_count == '0) res_status <= ST_EMPTY;
          end
          CMD_RECV, CMD_HB_SENT: res_ok <= 1'b1;
          CMD_TICK: begin
            if (!session_up) begin
              res_status <= ST_NOT_CONN;
            end else if (dt_recv >= TIME_W'(receive_timeout)) begin
              res_status <= ST_TIMEOUT;
            end else begin
              res_ok <= 1'b1;
            end
          end
          CMD_HB_QUERY: begin
            if (!session_up) begin
              res_status <= ST_NOT_CONN;
            end else if (dt_hb >= TIME_W'(heartbeat_period)) begin
              res_ok <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_ACC: begin
        // shift in the next partial product
        acc <= (acc << MUL_W) + ACC_W'(prod);
        idx <= idx - IDX_W'(1);
      end
      S_CHARGE: begin
        if (token_level < need) begin
          res_status <= ST_RATE_LIM;
        end else if (over_limit) begin
          if (overflow_mode == OVF_DISCONNECT) begin
            res_status <= ST_OVF_DISC;
          end else if (overflow_mode != OVF_DROP_OLD) begin
            res_status <= ST_REJECTED;
          end
        end
      end
      S_PUSH:     res_ok <= 1'b1;
      S_DEQ_WAIT: begin
        res_ok  <= 1'b1;
        res_len <= head_len;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/sapp_lenq.sv -----
// Length queue storage: one write port, one registered read port.
// Depends on sapp_pkg.
`default_nettype none
module sapp_lenq (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [sapp_pkg::HEAD_W-1:0] waddr,
  input  wire logic [sapp_pkg::LEN_W-1:0]  wdata,
  input  wire logic [sapp_pkg::HEAD_W-1:0] raddr,
  output logic      [sapp_pkg::LEN_W-1:0]  rdata
);
  import sapp_pkg::*;

  logic [LEN_W-1:0] mem [QDEPTH];

  // write one word, read the head word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/sapp_mul.sv -----
// Shared partial-product multiplier: one time chunk by the refill rate.
// Depends on sapp_pkg; the product is registered.
`default_nettype none
module sapp_mul (
  input  wire logic                        clk,
  input  wire logic [sapp_pkg::MUL_W-1:0]  a,
  input  wire logic [sapp_pkg::RATE_W-1:0] b,
  output logic      [sapp_pkg::PROD_W-1:0] p
);
  import sapp_pkg::*;

  // register the partial product
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire
